// ===== rtl/idt_pkg.sv =====
// shared constants, codes and types for the id table block
package idt_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int IDENT_BYTES = 7;
   localparam int IDENT_W = 56;
   localparam int LEN_W = 3;
   localparam int CMD_W = 2;
   localparam int COUNT_IN_W = 7;
   localparam int STATUS_W = 3;
   localparam int ADDR_W = 16;
   localparam int ROW_W = 8;
   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam int ENTRY_W = IDENT_W + LEN_W;

   localparam logic [ADDR_W-1:0] START_RESET = '0;
   localparam logic [ROW_W-1:0] ROW_RESET = ROW_W'(16);

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_COUNT  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED     = 3'd0,
      ST_FULL      = 3'd1,
      ST_FOUND     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_COUNT_SET = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_ADDRESS = 1'd0,
      CSR_ROW_SIZE      = 1'd1
   } csr_idx_type;

   typedef struct packed {
      logic [LEN_W-1:0]   len;
      logic [IDENT_W-1:0] bytes;
   } entry_type;

endpackage

// ===== rtl/idt_req_if.sv =====
// request channel interface of the id table block
interface idt_req_if;
   import idt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CMD_W-1:0]      cmd;
   logic [IDENT_W-1:0]    ident_bytes;
   logic [LEN_W-1:0]      ident_len;
   logic [COUNT_IN_W-1:0] new_count;
   modport source (output valid, cmd, ident_bytes, ident_len, new_count, input ready);
   modport sink (input valid, cmd, ident_bytes, ident_len, new_count, output ready);
endinterface

// ===== rtl/idt_rsp_if.sv =====
// response channel interface of the id table block
interface idt_rsp_if;
   import idt_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [IDX_W-1:0]    entry_index;
   logic [ADDR_W-1:0]   row_address;
   modport source (output valid, status, entry_index, row_address, input ready);
   modport sink (input valid, status, entry_index, row_address, output ready);
endinterface

// ===== rtl/idt_csr_if.sv =====
// register write channel interface of the id table block
interface idt_csr_if;
   import idt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/id_table_append_and_lookup.sv =====
// id table top level: append, linear-search lookup and entry count
//
//   channel   dir   words
//   req_chan  in    cmd, ident_bytes, ident_len, new_count
//   rsp_chan  out   status, entry_index, row_address
//   csr_chan  in    index, data (0 start_address, 1 row_size)
//
// add, set count: result registered straight from the accepted request
// lookup: scans entries from index 0 up to the first match, or through the
//   entry count when nothing matches; one ram read per entry scanned
// one word in flight; req_chan waits while a response is held unread
// reset: synchronous, table reads as zero through per-entry valid bits
module id_table_append_and_lookup (
   input logic        clock,
   input logic        reset,
   idt_req_if.sink    req_chan,
   idt_rsp_if.source  rsp_chan,
   idt_csr_if.sink    csr_chan
);
   import idt_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]      scan_idx_ff, scan_idx_in;
   entry_type             key_ff, key_in;
   logic [ADDR_W-1:0]     start_ff, start_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]      rsp_index_ff, rsp_index_in;
   logic [ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;

   logic                  req_fire;
   logic                  out_free;
   logic [LEN_W-1:0]      eff_len;
   entry_type             req_entry;
   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   logic [IDX_W-1:0]      ram_rd_addr;
   logic [ENTRY_W-1:0]    ram_rd_data;
   entry_type             scan_entry;
   logic                  scan_hit;
   logic                  scan_last;
   logic [IDX_W-1:0]      addr_idx;
   logic [ADDR_W-1:0]     idx_addr;

   idt_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_ENTRIES)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(req_entry),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && out_free;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.entry_index = rsp_index_ff;
   assign rsp_chan.row_address = rsp_addr_ff;

   // effective length and masked identifier
   always_comb begin
      eff_len = (req_chan.ident_len > LEN_W'(IDENT_BYTES)) ? LEN_W'(IDENT_BYTES)
                                                            : req_chan.ident_len;
      req_entry.len = eff_len;
      req_entry.bytes = '0;
      for (int b = 0; b < IDENT_BYTES; b++) begin
         if (LEN_W'(b) < eff_len) begin
            req_entry.bytes[8*b +: 8] = req_chan.ident_bytes[8*b +: 8];
         end
      end
   end

   assign ram_wr_en = req_fire && (req_chan.cmd == CMD_ADD) &&
                      (count_ff < CNT_W'(MAX_ENTRIES));
   assign ram_wr_addr = count_ff[IDX_W-1:0];
   assign ram_rd_addr = (state_ff == S_SCAN) ? scan_idx_ff + IDX_W'(1) : '0;

   assign scan_entry = valid_ff[scan_idx_ff] ? entry_type'(ram_rd_data) : '0;
   assign scan_hit = (scan_entry == key_ff);
   assign scan_last = ({1'b0, scan_idx_ff} + CNT_W'(1)) == count_ff;

   assign addr_idx = (state_ff == S_SCAN) ? scan_idx_ff : count_ff[IDX_W-1:0];
   assign idx_addr = start_ff + ADDR_W'(ADDR_W'(addr_idx) * ADDR_W'(row_ff));

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      valid_in = valid_ff;
      scan_idx_in = scan_idx_ff;
      key_in = key_ff;
      start_in = start_ff;
      row_in = row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in = rsp_index_ff;
      rsp_addr_in = rsp_addr_ff;

      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_START_ADDRESS: start_in = csr_chan.data;
            CSR_ROW_SIZE:      row_in = csr_chan.data[ROW_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_chan.cmd)
                  CMD_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff < CNT_W'(MAX_ENTRIES)) begin
                        rsp_status_in = ST_ADDED;
                        rsp_index_in = count_ff[IDX_W-1:0];
                        rsp_addr_in = idx_addr;
                        valid_in[count_ff[IDX_W-1:0]] = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        rsp_status_in = ST_FULL;
                        rsp_index_in = '0;
                        rsp_addr_in = '0;
                     end
                  end
                  CMD_LOOKUP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_status_in = ST_NOT_FOUND;
                        rsp_index_in = '0;
                        rsp_addr_in = '0;
                     end else begin
                        key_in = req_entry;
                        scan_idx_in = '0;
                        state_in = S_SCAN;
                     end
                  end
                  CMD_COUNT: begin
                     rsp_valid_in = 1'b1;
                     rsp_status_in = ST_COUNT_SET;
                     rsp_index_in = '0;
                     rsp_addr_in = '0;
                     count_in = (req_chan.new_count > COUNT_IN_W'(MAX_ENTRIES))
                                ? CNT_W'(MAX_ENTRIES) : CNT_W'(req_chan.new_count);
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            if (scan_hit) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = ST_FOUND;
               rsp_index_in = scan_idx_ff;
               rsp_addr_in = idx_addr;
               state_in = S_IDLE;
            end else if (scan_last) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = ST_NOT_FOUND;
               rsp_index_in = '0;
               rsp_addr_in = '0;
               state_in = S_IDLE;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         valid_ff <= '0;
         start_ff <= START_RESET;
         row_ff <= ROW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         start_ff <= start_in;
         row_ff <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_idx_ff <= scan_idx_in;
      key_ff <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff <= rsp_index_in;
      rsp_addr_ff <= rsp_addr_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count above capacity");

   a_scan_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> !rsp_valid_ff)
      else $error("response held while scanning");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> ({1'b0, scan_idx_ff} < count_ff))
      else $error("scan index past entry count");

   a_lookup_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.cmd == CMD_LOOKUP && count_ff != '0 |=> state_ff == S_SCAN)
      else $error("lookup did not start a scan");

   a_add_marks_valid: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> valid_ff[$past(ram_wr_addr)])
      else $error("added entry not marked valid");

endmodule

// ===== rtl/idt_ram.sv =====
// generic single-clock ram, one write port and one registered read port
module idt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
